@@ rtl/lfsr_keystream_xor_cipher_macros.svh @@
// Assertion helpers for the keystream cipher.
`ifndef LFSR_KEYSTREAM_XOR_CIPHER_MACROS_SVH
`define LFSR_KEYSTREAM_XOR_CIPHER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LKXC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LKXC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lkxc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lkxc_pkg;

    localparam int unsigned LFSR_W = 8;
    localparam int unsigned TAP_W  = 3;
    localparam int unsigned IDX_W  = 2;

    localparam logic [LFSR_W-1:0] SEED_RESET       = 8'hAA;
    localparam logic [TAP_W-1:0]  TAP_FIRST_RESET  = 3'd2;
    localparam logic [TAP_W-1:0]  TAP_SECOND_RESET = 3'd5;
    localparam logic [TAP_W-1:0]  TAP_TOP          = 3'd7;

    typedef enum logic [IDX_W-1:0] {
        CFG_SEED       = 2'd0,
        CFG_TAP_FIRST  = 2'd1,
        CFG_TAP_SECOND = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [TAP_W-1:0] tap_first;
        logic [TAP_W-1:0] tap_second;
    } t_taps;

endpackage

`default_nettype wire

@@ rtl/lkxc_keygen.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lkxc_keygen (
    input  wire  logic [lkxc_pkg::LFSR_W-1:0] i_state,
    input  wire  lkxc_pkg::t_taps             i_taps,
    output logic [lkxc_pkg::LFSR_W-1:0]       o_keystream,
    output logic [lkxc_pkg::LFSR_W-1:0]       o_next_state
);

    logic [lkxc_pkg::TAP_W-1:0]  w_pos_first;
    logic [lkxc_pkg::TAP_W-1:0]  w_pos_second;

    assign w_pos_first  = lkxc_pkg::TAP_TOP - i_taps.tap_first;
    assign w_pos_second = lkxc_pkg::TAP_TOP - i_taps.tap_second;

    // Eight unrolled shift-right steps, feedback into the top bit.
    always_comb begin
        logic [lkxc_pkg::LFSR_W-1:0] v_r;
        logic                        v_fb;
        v_r         = i_state;
        o_keystream = '0;
        for (int k = 0; k < int'(lkxc_pkg::LFSR_W); k++) begin
            o_keystream[k] = v_r[0];
            v_fb           = v_r[w_pos_first] ^ v_r[w_pos_second];
            v_r            = {v_fb, v_r[lkxc_pkg::LFSR_W-1:1]};
        end
        o_next_state = v_r;
    end

endmodule

`default_nettype wire

@@ rtl/lfsr_keystream_xor_cipher.sv @@
// XOR stream cipher, 8-bit Fibonacci LFSR keystream, one byte per transfer.
// Input channel (i_in_valid/o_in_ready): data byte plus a restart flag that
// reloads the LFSR from the seed register before the byte is processed.
// Output channel (o_out_valid/i_out_ready): result byte and keystream byte.
// Config channel (i_cfg_valid/o_cfg_ready, always ready): index 0 seed,
// 1 first tap, 2 second tap, index 3 ignored. Write only while idle.
// A seed write takes effect at the next restart.
// Path: input register, then result register. Throughput: one byte per
// cycle while the receiver keeps up, set by the eight-step keystream unroll
// between the two registers.
// Reset: pipeline empties, seed 0xAA, taps 2 and 5, LFSR loaded with 0xAA.
// Stall: a held result keeps its register; the input register still takes
// one byte, then o_in_ready drops until the receiver takes the result.
`timescale 1ns / 1ps
`default_nettype none
`include "lfsr_keystream_xor_cipher_macros.svh"

module lfsr_keystream_xor_cipher (
    input  wire  logic                             i_clk,
    input  wire  logic                             i_rst_n,
    input  wire  logic                             i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire  logic [lkxc_pkg::IDX_W-1:0]       i_cfg_index,
    input  wire  logic [lkxc_pkg::LFSR_W-1:0]      i_cfg_data,
    input  wire  logic                             i_in_valid,
    output logic                                   o_in_ready,
    input  wire  logic [lkxc_pkg::LFSR_W-1:0]      i_data_byte,
    input  wire  logic                             i_restart,
    output logic                                   o_out_valid,
    input  wire  logic                             i_out_ready,
    output logic [lkxc_pkg::LFSR_W-1:0]            o_result_byte,
    output logic [lkxc_pkg::LFSR_W-1:0]            o_keystream_byte
);

    logic [lkxc_pkg::LFSR_W-1:0] r_seed;
    lkxc_pkg::t_taps             r_taps;
    logic [lkxc_pkg::LFSR_W-1:0] r_lfsr;

    logic                        r_s1_valid;
    logic [lkxc_pkg::LFSR_W-1:0] r_s1_data;
    logic                        r_s1_restart;

    logic                        r_out_valid;
    logic [lkxc_pkg::LFSR_W-1:0] r_result;
    logic [lkxc_pkg::LFSR_W-1:0] r_ks;

    logic                        w_s1_fire;
    logic                        w_in_fire;
    logic [lkxc_pkg::LFSR_W-1:0] w_start;
    logic [lkxc_pkg::LFSR_W-1:0] w_ks;
    logic [lkxc_pkg::LFSR_W-1:0] n_lfsr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed            <= lkxc_pkg::SEED_RESET;
            r_taps.tap_first  <= lkxc_pkg::TAP_FIRST_RESET;
            r_taps.tap_second <= lkxc_pkg::TAP_SECOND_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lkxc_pkg::CFG_SEED:       r_seed            <= i_cfg_data;
                lkxc_pkg::CFG_TAP_FIRST:  r_taps.tap_first  <= i_cfg_data[lkxc_pkg::TAP_W-1:0];
                lkxc_pkg::CFG_TAP_SECOND: r_taps.tap_second <= i_cfg_data[lkxc_pkg::TAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Stage 1 moves on when the result register is free or being drained.
    assign w_s1_fire  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || w_s1_fire;
    assign w_in_fire  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_data    <= i_data_byte;
            r_s1_restart <= i_restart;
        end
    end

    assign w_start = r_s1_restart ? r_seed : r_lfsr;

    lkxc_keygen u_keygen (
        .i_state      (w_start),
        .i_taps       (r_taps),
        .o_keystream  (w_ks),
        .o_next_state (n_lfsr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= lkxc_pkg::SEED_RESET;
        end else if (w_s1_fire) begin
            r_lfsr <= n_lfsr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire) begin
            r_result <= r_s1_data ^ w_ks;
            r_ks     <= w_ks;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_byte    = r_result;
    assign o_keystream_byte = r_ks;

    // Equal taps cancel, so eight steps leave the register empty.
    `LKXC_ASSERT_NEXT(a_equal_taps_drain, i_clk, i_rst_n,
        w_s1_fire && (r_taps.tap_first == r_taps.tap_second), r_lfsr == '0,
        "LFSR not drained with equal taps")
    // First keystream bit is bit 0 of the running LFSR when no restart.
    `LKXC_ASSERT_NEXT(a_first_ks_bit, i_clk, i_rst_n,
        w_s1_fire && !r_s1_restart, o_keystream_byte[0] == $past(r_lfsr[0]),
        "keystream bit 0 mismatch")
    // A held stage-1 item keeps its payload.
    `LKXC_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n,
        r_s1_valid && !w_s1_fire, r_s1_valid && $stable(r_s1_data),
        "stage 1 item lost while stalled")
    // The LFSR only advances when an item leaves stage 1.
    `LKXC_ASSERT_NEXT(a_lfsr_quiet, i_clk, i_rst_n,
        !w_s1_fire, $stable(r_lfsr),
        "LFSR moved without a transfer")

endmodule

`default_nettype wire

@@ dv/lfsr_keystream_xor_cipher_tb.sv @@
`timescale 1ns / 1ps

module lfsr_keystream_xor_cipher_tb;
    import lkxc_pkg::*;

    localparam int PIPE_LATENCY = 2;
    localparam int CYCLE_LIMIT  = 300000;
    localparam logic [IDX_W-1:0] CFG_RESERVED = 2'd3;

    typedef struct packed {
        logic [LFSR_W-1:0] result_byte;
        logic [LFSR_W-1:0] keystream_byte;
    } t_cipher_out;

    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 i_cfg_valid      = 1'b0;
    logic                 o_cfg_ready;
    logic [IDX_W-1:0]     i_cfg_index      = '0;
    logic [LFSR_W-1:0]    i_cfg_data       = '0;
    logic                 i_in_valid       = 1'b0;
    logic                 o_in_ready;
    logic [LFSR_W-1:0]    i_data_byte      = '0;
    logic                 i_restart        = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready      = 1'b0;
    logic [LFSR_W-1:0]    o_result_byte;
    logic [LFSR_W-1:0]    o_keystream_byte;

    // shadow of the block's registers and LFSR
    logic [LFSR_W-1:0]    shadow_seed       = SEED_RESET;
    logic [TAP_W-1:0]     shadow_tap_first  = TAP_FIRST_RESET;
    logic [TAP_W-1:0]     shadow_tap_second = TAP_SECOND_RESET;
    logic [LFSR_W-1:0]    shadow_lfsr       = SEED_RESET;

    t_cipher_out          cipher_out_q[$];
    int                   mismatch_count = 0;
    int unsigned          cycle_count    = 0;
    bit                   in_idle_en     = 1'b0;
    bit                   out_idle_en    = 1'b0;
    int                   hold_left      = 0;
    int                   stall_left     = 0;

    lfsr_keystream_xor_cipher uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_restart        (i_restart),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_byte    (o_result_byte),
        .o_keystream_byte (o_keystream_byte)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("lfsr_keystream_xor_cipher: mismatch");
            $finish;
        end
    end

    // keystream: bit 0 out first, feedback enters at the top
    function automatic t_cipher_out cipher_predict(input logic [LFSR_W-1:0] data,
                                                   input logic restart);
        t_cipher_out       o;
        logic [LFSR_W-1:0] r;
        logic              fb;
        int                k;
        r = restart ? shadow_seed : shadow_lfsr;
        for (k = 0; k < LFSR_W; k++) begin
            o.keystream_byte[k] = r[0];
            fb = r[TAP_TOP - shadow_tap_first] ^ r[TAP_TOP - shadow_tap_second];
            r  = {fb, r[LFSR_W-1:1]};
        end
        shadow_lfsr   = r;
        o.result_byte = data ^ o.keystream_byte;
        return o;
    endfunction

    task automatic note_mismatch(input string what, input logic [LFSR_W-1:0] want,
                                 input logic [LFSR_W-1:0] got);
        if (mismatch_count < 10)
            $display("%0t: %s expected %02h actual %02h", $realtime, what, want, got);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_cipher_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cipher_out_q.size() == 0) begin
                note_mismatch("unexpected transfer, result_byte", 8'h00, o_result_byte);
            end else begin
                want = cipher_out_q.pop_front();
                if (o_result_byte !== want.result_byte)
                    note_mismatch("result_byte", want.result_byte, o_result_byte);
                if (o_keystream_byte !== want.keystream_byte)
                    note_mismatch("keystream_byte", want.keystream_byte, o_keystream_byte);
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(negedge i_clk) begin
        if (stall_left > 0)
            stall_left = stall_left - 1;
        else if (out_idle_en && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 14);
        i_out_ready <= i_rst_n && (hold_left == 0) && (stall_left == 0);
    end

    task automatic send_byte(input logic [LFSR_W-1:0] data, input logic restart);
        int gap;
        @(negedge i_clk);
        if (in_idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 14);
            repeat (gap) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= data;
        i_restart   <= restart;
        do @(posedge i_clk); while (!o_in_ready);
        cipher_out_q.push_back(cipher_predict(data, restart));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (cipher_out_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [LFSR_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SEED:       shadow_seed       = data;
            CFG_TAP_FIRST:  shadow_tap_first  = data[TAP_W-1:0];
            CFG_TAP_SECOND: shadow_tap_second = data[TAP_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_cipher(input logic [LFSR_W-1:0] seed, input logic [LFSR_W-1:0] t1,
                              input logic [LFSR_W-1:0] t2);
        wait_idle();
        cfg_write(CFG_SEED, seed);
        cfg_write(CFG_TAP_FIRST, t1);
        cfg_write(CFG_TAP_SECOND, t2);
    endtask

    // LFSR runs from its reset contents without any restart
    task automatic test_reset_state();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
    endtask

    task automatic test_data_extremes();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b1);
    endtask

    // new seed must not disturb the running LFSR until a restart
    task automatic test_seed_deferred();
        wait_idle();
        cfg_write(CFG_SEED, 8'h01);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b1);
        send_byte(8'h0F, 1'b0);
    endtask

    // equal taps cancel, register drains to zero
    task automatic test_equal_taps();
        set_cipher(8'hFF, 8'h03, 8'hFB);
        send_byte(8'h12, 1'b1);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
    endtask

    // zero register keeps the keystream at zero until a nonzero restart
    task automatic test_zero_register();
        set_cipher(8'h00, 8'h00, 8'h07);
        send_byte(8'h81, 1'b1);
        send_byte(8'h7E, 1'b0);
        wait_idle();
        cfg_write(CFG_SEED, 8'h80);
        send_byte(8'hF0, 1'b0);
        send_byte(8'hF0, 1'b1);
    endtask

    // widest taps, masked upper bits, and the unused index
    task automatic test_tap_extremes();
        set_cipher(8'hFF, 8'hF8, 8'h07);
        wait_idle();
        cfg_write(CFG_RESERVED, 8'hFF);
        cfg_write(CFG_RESERVED, 8'h00);
        send_byte(8'h55, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h01, 1'b0);
    endtask

    task automatic send_messages(input int count);
        int n, len, k;
        n = 0;
        while (n < count) begin
            len = $urandom_range(1, 24);
            for (k = 0; k < len; k++) begin
                send_byte(8'($urandom_range(0, 255)),
                          (k == 0) || ($urandom_range(0, 29) == 0));
                n++;
            end
        end
    endtask

    task automatic test_random_stream();
        int phase;
        for (phase = 0; phase < 10; phase++) begin
            case (phase)
                0: set_cipher(8'hFF, 8'h00, 8'h07);
                1: set_cipher(8'h00, 8'h07, 8'h00);
                2: set_cipher(8'h01, 8'h07, 8'h07);
                3: set_cipher(SEED_RESET, {5'h1F, TAP_FIRST_RESET}, {5'h00, TAP_SECOND_RESET});
                default: set_cipher(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)));
            endcase
            send_messages(95);
        end
    endtask

    // receiver stops for a long stretch, sender keeps offering
    task automatic test_backpressure();
        bit saved;
        saved = in_idle_en;
        in_idle_en = 1'b0;
        @(negedge i_clk);
        hold_left = 300;
        send_messages(40);
        in_idle_en = saved;
    endtask

    task automatic test_full_rate();
        set_cipher(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
        send_messages(200);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
        test_reset_state();
        test_data_extremes();
        test_seed_deferred();
        test_equal_taps();
        test_zero_register();
        test_tap_extremes();
        test_random_stream();
        test_backpressure();
        wait_idle();
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
        test_full_rate();
        wait_idle();
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);
        if (mismatch_count == 0 && cipher_out_q.size() == 0) begin
            $display("lfsr_keystream_xor_cipher: match");
        end else begin
            $display("lfsr_keystream_xor_cipher: mismatch");
        end
        $finish;
    end

endmodule
